### rtl/u8tr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8tr_pkg
// Shared widths, reset values, register indexes and status types for the
// tick-driven 8N1 serial transceiver.
// ----------------------------------------------------------------------------
package u8tr_pkg;

    // field and register widths
    localparam int BYTE_W      = 8;
    localparam int BIT_TICKS_W = 16;
    localparam int GUARD_W     = 20;
    localparam int OFFSET_W    = 16;
    localparam int TX_COUNT_W  = 21;
    localparam int RX_COUNT_W  = 17;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

    // default frame width
    localparam int DATA_BITS_DEFAULT = 8;

    // register reset values
    localparam logic [BIT_TICKS_W-1:0] BIT_TICKS_RESET = BIT_TICKS_W'(800);
    localparam logic [GUARD_W-1:0]     GUARD_RESET     = GUARD_W'(20000);
    localparam logic [OFFSET_W-1:0]    OFFSET_RESET    = OFFSET_W'(800);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_TICKS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_TX_GUARD  = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_RX_OFFSET = CFG_INDEX_W'(2);

    // transmitter status for one tick
    typedef struct packed {
        logic tx_busy;
        logic tx_line;
    } tx_status_t;

    // receiver status for one tick
    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              rx_valid;
        logic              rx_busy;
    } rx_status_t;

endpackage

### rtl/uart_8n1_tx_rx_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_8n1_tx_rx_top
// Tick-driven 8N1 serial transceiver: one input transfer per line tick, one
// status transfer out per tick, plus a register write channel.
//
//   channel  dir  fields (lsb first)
//   s_       in   rx_line, tx_start, tx_byte[7:0]
//   m_       out  tx_line, tx_busy, rx_busy, rx_valid, rx_byte[7:0]
//   cfg_     in   index 0 bit_ticks, 1 tx_guard_ticks, 2 rx_start_offset
//
// One tick per clock cycle: each input transfer is worked through the tx and
// rx engines in the same cycle and lands in the output register, so a new
// tick is taken every cycle while the output side keeps up.
// The output register decides the rate: s_tready drops only while a result
// is held and m_tready is low; the engines stop with it.
// aresetn is synchronous, active low; it loads default register values.
// Register writes are taken every cycle (cfg_ready is always high).
// ----------------------------------------------------------------------------
module uart_8n1_tx_rx_top #(
    parameter int DATA_BITS = u8tr_pkg::DATA_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] rx_line, [1] tx_start, [9:2] tx_byte, [15:10] zero
    input  logic [u8tr_pkg::S_TDATA_W-1:0]      s_tdata,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] tx_line, [1] tx_busy, [2] rx_busy, [3] rx_valid, [11:4] rx_byte,
    // [15:12] zero
    output logic [u8tr_pkg::M_TDATA_W-1:0]      m_tdata,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [u8tr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [u8tr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [u8tr_pkg::BIT_TICKS_W-1:0]  bit_ticks_reg;
    logic [u8tr_pkg::GUARD_W-1:0]      guard_reg;
    logic [u8tr_pkg::OFFSET_W-1:0]     offset_reg;
    logic [u8tr_pkg::BIT_TICKS_W-1:0]  period;
    logic                              m_tvalid_reg;
    logic [u8tr_pkg::M_TDATA_W-1:0]    m_tdata_reg;
    logic                              step;
    u8tr_pkg::tx_status_t              tx_status;
    u8tr_pkg::rx_status_t              rx_status;

    // register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_ticks_reg <= u8tr_pkg::BIT_TICKS_RESET;
            guard_reg     <= u8tr_pkg::GUARD_RESET;
            offset_reg    <= u8tr_pkg::OFFSET_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                u8tr_pkg::CFG_BIT_TICKS: bit_ticks_reg <= cfg_data[u8tr_pkg::BIT_TICKS_W-1:0];
                u8tr_pkg::CFG_TX_GUARD:  guard_reg     <= cfg_data[u8tr_pkg::GUARD_W-1:0];
                u8tr_pkg::CFG_RX_OFFSET: offset_reg    <= cfg_data[u8tr_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // a zero bit period counts as one tick
    assign period = (bit_ticks_reg == '0) ? u8tr_pkg::BIT_TICKS_W'(1) : bit_ticks_reg;

    // input transfer advances both engines by one tick
    assign s_tready = !m_tvalid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    u8tr_tx #(
        .DATA_BITS   (DATA_BITS)
    ) u_tx (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .tx_start    (s_tdata[1]),
        .tx_byte     (s_tdata[9:2]),
        .period      (period),
        .guard_ticks (guard_reg),
        .status      (tx_status)
    );

    u8tr_rx #(
        .DATA_BITS    (DATA_BITS)
    ) u_rx (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .rx_line      (s_tdata[0]),
        .period       (period),
        .start_offset (offset_reg),
        .status       (rx_status)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_tdata_reg <= u8tr_pkg::M_TDATA_W'({rx_status.rx_byte, rx_status.rx_valid,
                                                 rx_status.rx_busy, tx_status.tx_busy,
                                                 tx_status.tx_line});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a received byte is only reported inside a busy receive
    a_valid_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[3]) |-> m_tdata_reg[2])
        else $error("rx_valid without rx_busy");

    // the line idles high whenever the transmitter is not busy
    a_idle_line_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tdata_reg[1]) |-> m_tdata_reg[0])
        else $error("tx line low while idle");

    // rx_byte reads zero except on the tick that reports rx_valid
    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tdata_reg[3]) |-> (m_tdata_reg[11:4] == '0))
        else $error("rx_byte nonzero without rx_valid");

endmodule

### rtl/u8tr_tx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8tr_tx
// Transmit engine: guard and lead time, start bit, data bits lsb first,
// stop bit. Advances by one tick on each step.
// ----------------------------------------------------------------------------
module u8tr_tx #(
    parameter int DATA_BITS = u8tr_pkg::DATA_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               step,
    input  logic                               tx_start,
    input  logic [u8tr_pkg::BYTE_W-1:0]        tx_byte,
    input  logic [u8tr_pkg::BIT_TICKS_W-1:0]   period,
    input  logic [u8tr_pkg::GUARD_W-1:0]       guard_ticks,
    output u8tr_pkg::tx_status_t               status
);

    localparam int IDX_W = $clog2(DATA_BITS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_BITS - 1);

    typedef enum logic [2:0] {
        TX_IDLE,
        TX_LEAD,
        TX_START,
        TX_DATA,
        TX_STOP
    } tx_phase_t;

    tx_phase_t                            phase_reg, phase_next, phase_cur;
    logic [u8tr_pkg::TX_COUNT_W-1:0]      count_reg, count_next, count_cur, count_dec;
    logic [u8tr_pkg::BYTE_W-1:0]          shift_reg, shift_next;
    logic [IDX_W-1:0]                     idx_reg, idx_next, idx_cur;
    logic                                 begin_frame;
    logic                                 line;

    // take a request while idle, then count down the current period
    always_comb begin
        begin_frame = (phase_reg == TX_IDLE) && tx_start;
        phase_cur   = begin_frame ? TX_LEAD : phase_reg;
        count_cur   = begin_frame
                    ? (u8tr_pkg::TX_COUNT_W'(guard_ticks) + u8tr_pkg::TX_COUNT_W'(period))
                    : count_reg;
        shift_next  = begin_frame ? tx_byte : shift_reg;
        idx_cur     = begin_frame ? '0 : idx_reg;
        count_dec   = count_cur - u8tr_pkg::TX_COUNT_W'(count_cur != '0);

        case (phase_cur)
            TX_START: line = 1'b0;
            TX_DATA:  line = (int'(idx_cur) < u8tr_pkg::BYTE_W) ? shift_next[idx_cur[2:0]] : 1'b0;
            default:  line = 1'b1;
        endcase

        phase_next = phase_cur;
        count_next = count_cur;
        idx_next   = idx_cur;
        if (phase_cur != TX_IDLE) begin
            count_next = count_dec;
            if (count_dec == '0) begin
                case (phase_cur)
                    TX_LEAD: begin
                        phase_next = TX_START;
                        count_next = u8tr_pkg::TX_COUNT_W'(period);
                    end
                    TX_START: begin
                        phase_next = TX_DATA;
                        idx_next   = '0;
                        count_next = u8tr_pkg::TX_COUNT_W'(period);
                    end
                    TX_DATA: begin
                        if (idx_cur >= LAST_IDX) begin
                            phase_next = TX_STOP;
                        end else begin
                            idx_next = idx_cur + IDX_W'(1);
                        end
                        count_next = u8tr_pkg::TX_COUNT_W'(period);
                    end
                    default: begin
                        phase_next = TX_IDLE;
                        count_next = '0;
                    end
                endcase
            end
        end
    end

    assign status.tx_line = line;
    assign status.tx_busy = (phase_cur != TX_IDLE);

    // state holds between transfers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= TX_IDLE;
            count_reg <= '0;
            shift_reg <= '0;
            idx_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
            idx_reg   <= idx_next;
        end
    end

    // an idle transmitter has no running count
    a_idle_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == TX_IDLE) |-> (count_reg == '0))
        else $error("tx idle with nonzero count");

endmodule

### rtl/u8tr_rx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8tr_rx
// Receive engine: falling-edge start, start offset, one sample per bit
// period lsb first. Advances by one tick on each step.
// ----------------------------------------------------------------------------
module u8tr_rx #(
    parameter int DATA_BITS = u8tr_pkg::DATA_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               step,
    input  logic                               rx_line,
    input  logic [u8tr_pkg::BIT_TICKS_W-1:0]   period,
    input  logic [u8tr_pkg::OFFSET_W-1:0]      start_offset,
    output u8tr_pkg::rx_status_t               status
);

    localparam int IDX_W = $clog2(DATA_BITS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_BITS - 1);

    typedef enum logic {
        RX_IDLE,
        RX_BUSY
    } rx_phase_t;

    rx_phase_t                            phase_reg, phase_next;
    logic [u8tr_pkg::RX_COUNT_W-1:0]      count_reg, count_next, count_dec;
    logic [DATA_BITS-1:0]                 shift_reg, shift_next;
    logic [IDX_W-1:0]                     idx_reg, idx_next;
    logic                                 prev_reg;
    logic                                 busy, valid;
    logic [u8tr_pkg::BYTE_W+DATA_BITS-1:0] shift_wide;

    // edge detect while idle, sample when the period count runs out
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        idx_next   = idx_reg;
        busy       = 1'b0;
        valid      = 1'b0;
        count_dec  = count_reg - u8tr_pkg::RX_COUNT_W'(count_reg != '0);

        case (phase_reg)
            RX_IDLE: begin
                if (prev_reg && !rx_line) begin
                    phase_next = RX_BUSY;
                    count_next = u8tr_pkg::RX_COUNT_W'(start_offset)
                               + u8tr_pkg::RX_COUNT_W'(period);
                    idx_next   = '0;
                    busy       = 1'b1;
                end
            end
            default: begin
                busy       = 1'b1;
                count_next = count_dec;
                if (count_dec == '0) begin
                    shift_next[idx_reg] = rx_line;
                    if (idx_reg >= LAST_IDX) begin
                        valid      = 1'b1;
                        phase_next = RX_IDLE;
                        idx_next   = '0;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        count_next = u8tr_pkg::RX_COUNT_W'(period);
                    end
                end
            end
        endcase

        shift_wide = {u8tr_pkg::BYTE_W'(0), shift_next};
    end

    assign status.rx_busy  = busy;
    assign status.rx_valid = valid;
    assign status.rx_byte  = valid ? shift_wide[u8tr_pkg::BYTE_W-1:0] : '0;

    // state holds between transfers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= RX_IDLE;
            count_reg <= '0;
            shift_reg <= '0;
            idx_reg   <= '0;
            prev_reg  <= 1'b1;
        end else if (step) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
            idx_reg   <= idx_next;
            prev_reg  <= rx_line;
        end
    end

    // a finished byte always returns the receiver to idle
    a_valid_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && valid) |=> (phase_reg == RX_IDLE && idx_reg == '0))
        else $error("rx not idle after last sample");

endmodule

### tb/sv/uart_8n1_tx_rx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_8n1_tx_rx_checker
// Watches the tick, status and register channels of the 8N1 transceiver. It
// keeps its own tx and rx engines, works out the status of every accepted
// tick and compares each status transfer, field by field, with the oldest
// status still waiting.
// ----------------------------------------------------------------------------
module uart_8n1_tx_rx_checker #(
    parameter int DATA_BITS = u8tr_pkg::DATA_BITS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // [0] rx_line, [1] tx_start, [9:2] tx_byte, [15:10] zero
    input  logic [u8tr_pkg::S_TDATA_W-1:0]   s_tdata,

    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] tx_line, [1] tx_busy, [2] rx_busy, [3] rx_valid, [11:4] rx_byte
    input  logic [u8tr_pkg::M_TDATA_W-1:0]   m_tdata,

    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [u8tr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [u8tr_pkg::CFG_DATA_W-1:0]  cfg_data,

    output int                               error_count,
    output int                               outstanding
);

    typedef enum logic [2:0] {
        TX_IDLE,
        TX_LEAD,
        TX_START,
        TX_DATA,
        TX_STOP
    } tx_phase_t;

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_BUSY
    } rx_phase_t;

    typedef struct packed {
        logic                        tx_line;
        logic                        tx_busy;
        logic                        rx_busy;
        logic                        rx_valid;
        logic [u8tr_pkg::BYTE_W-1:0] rx_byte;
    } line_status_t;

    // register copies
    logic [u8tr_pkg::BIT_TICKS_W-1:0] bit_ticks;
    logic [u8tr_pkg::GUARD_W-1:0]     guard_ticks;
    logic [u8tr_pkg::OFFSET_W-1:0]    start_offset;

    // engine copies
    tx_phase_t                        tx_phase;
    logic [u8tr_pkg::TX_COUNT_W-1:0]  tx_count;
    logic [u8tr_pkg::BYTE_W-1:0]      tx_shift;
    logic [3:0]                       tx_bit;
    rx_phase_t                        rx_phase;
    logic [u8tr_pkg::RX_COUNT_W-1:0]  rx_count;
    logic [15:0]                      rx_shift;
    logic [3:0]                       rx_bit;
    logic                             rx_prev;

    line_status_t                     expected_status[$];

    // a zero period behaves as one tick
    function automatic logic [u8tr_pkg::BIT_TICKS_W-1:0] bit_period();
        return (bit_ticks == '0) ? u8tr_pkg::BIT_TICKS_W'(1) : bit_ticks;
    endfunction

    // one line tick through both engines
    task automatic advance_one_tick(input logic rx_line, input logic tx_start,
                                    input logic [u8tr_pkg::BYTE_W-1:0] tx_byte,
                                    output line_status_t st);
        st = '0;
        st.tx_line = 1'b1;

        // transmitter: requests while busy are dropped
        if (tx_phase == TX_IDLE && tx_start) begin
            tx_phase = TX_LEAD;
            tx_count = u8tr_pkg::TX_COUNT_W'(guard_ticks)
                     + u8tr_pkg::TX_COUNT_W'(bit_period());
            tx_shift = tx_byte;
            tx_bit   = '0;
        end
        case (tx_phase)
            TX_START: st.tx_line = 1'b0;
            TX_DATA:  st.tx_line = (tx_bit < 8) ? tx_shift[tx_bit[2:0]] : 1'b0;
            default:  st.tx_line = 1'b1;
        endcase
        st.tx_busy = (tx_phase != TX_IDLE);
        if (tx_phase != TX_IDLE) begin
            if (tx_count != '0)
                tx_count = tx_count - u8tr_pkg::TX_COUNT_W'(1);
            if (tx_count == '0) begin
                case (tx_phase)
                    TX_LEAD: begin
                        tx_phase = TX_START;
                        tx_count = u8tr_pkg::TX_COUNT_W'(bit_period());
                    end
                    TX_START: begin
                        tx_phase = TX_DATA;
                        tx_bit   = '0;
                        tx_count = u8tr_pkg::TX_COUNT_W'(bit_period());
                    end
                    TX_DATA: begin
                        if (tx_bit >= DATA_BITS - 1)
                            tx_phase = TX_STOP;
                        else
                            tx_bit = tx_bit + 4'd1;
                        tx_count = u8tr_pkg::TX_COUNT_W'(bit_period());
                    end
                    default: begin
                        tx_phase = TX_IDLE;
                        tx_count = '0;
                    end
                endcase
            end
        end

        // receiver: edges while busy are ignored
        if (rx_phase == RX_IDLE) begin
            if (rx_prev && !rx_line) begin
                rx_phase   = RX_BUSY;
                rx_count   = u8tr_pkg::RX_COUNT_W'(start_offset)
                           + u8tr_pkg::RX_COUNT_W'(bit_period());
                rx_bit     = '0;
                st.rx_busy = 1'b1;
            end
        end else begin
            st.rx_busy = 1'b1;
            if (rx_count != '0)
                rx_count = rx_count - u8tr_pkg::RX_COUNT_W'(1);
            if (rx_count == '0) begin
                rx_shift[rx_bit] = rx_line;
                if (rx_bit >= DATA_BITS - 1) begin
                    st.rx_valid = 1'b1;
                    st.rx_byte  = rx_shift[u8tr_pkg::BYTE_W-1:0];
                    rx_phase    = RX_IDLE;
                    rx_bit      = '0;
                end else begin
                    rx_bit   = rx_bit + 4'd1;
                    rx_count = u8tr_pkg::RX_COUNT_W'(bit_period());
                end
            end
        end
        rx_prev = rx_line;
    endtask

    task automatic check_field(input string name, input logic [u8tr_pkg::BYTE_W-1:0] want,
                               input logic [u8tr_pkg::BYTE_W-1:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // compare, predict and follow register writes at each edge
    always @(posedge aclk) begin
        line_status_t want;
        line_status_t got;
        line_status_t st;
        if (!aresetn) begin
            bit_ticks    = u8tr_pkg::BIT_TICKS_RESET;
            guard_ticks  = u8tr_pkg::GUARD_RESET;
            start_offset = u8tr_pkg::OFFSET_RESET;
            tx_phase     = TX_IDLE;
            tx_count     = '0;
            tx_shift     = '0;
            tx_bit       = '0;
            rx_phase     = RX_IDLE;
            rx_count     = '0;
            rx_shift     = '0;
            rx_bit       = '0;
            rx_prev      = 1'b1;
            error_count  = 0;
            expected_status.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.tx_line  = m_tdata[0];
                got.tx_busy  = m_tdata[1];
                got.rx_busy  = m_tdata[2];
                got.rx_valid = m_tdata[3];
                got.rx_byte  = m_tdata[11:4];
                if (expected_status.size() == 0) begin
                    error_count++;
                    $display("%0t: status transfer with nothing expected, actual %0h",
                             $time, m_tdata);
                end else begin
                    want = expected_status.pop_front();
                    check_field("tx_line", u8tr_pkg::BYTE_W'(want.tx_line),
                                u8tr_pkg::BYTE_W'(got.tx_line));
                    check_field("tx_busy", u8tr_pkg::BYTE_W'(want.tx_busy),
                                u8tr_pkg::BYTE_W'(got.tx_busy));
                    check_field("rx_busy", u8tr_pkg::BYTE_W'(want.rx_busy),
                                u8tr_pkg::BYTE_W'(got.rx_busy));
                    check_field("rx_valid", u8tr_pkg::BYTE_W'(want.rx_valid),
                                u8tr_pkg::BYTE_W'(got.rx_valid));
                    check_field("rx_byte", want.rx_byte, got.rx_byte);
                end
            end
            if (s_tvalid && s_tready) begin
                advance_one_tick(s_tdata[0], s_tdata[1], s_tdata[9:2], st);
                expected_status.push_back(st);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    u8tr_pkg::CFG_BIT_TICKS:
                        bit_ticks    = cfg_data[u8tr_pkg::BIT_TICKS_W-1:0];
                    u8tr_pkg::CFG_TX_GUARD:
                        guard_ticks  = cfg_data[u8tr_pkg::GUARD_W-1:0];
                    u8tr_pkg::CFG_RX_OFFSET:
                        start_offset = cfg_data[u8tr_pkg::OFFSET_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding = expected_status.size();
    end

endmodule

### tb/sv/uart_8n1_tx_rx_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_8n1_tx_rx_top_tb
// Drives line ticks into the 8N1 transceiver: a short directed run over
// back-to-back frames, ignored requests, edges while busy, zero bit period
// and a register change mid-frame, then random episodes of serial frames,
// noise and transmit requests under several settings and idling phases.
// The checker beside the block predicts and compares every status transfer.
// ----------------------------------------------------------------------------
module uart_8n1_tx_rx_top_tb;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS    = 1150;
    localparam int DIRECTED_TICKS  = 30;
    localparam int TAIL_CYCLES     = 16;
    localparam logic [u8tr_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED = u8tr_pkg::CFG_INDEX_W'(3);

    logic                             aclk;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [u8tr_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [u8tr_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [u8tr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [u8tr_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    int error_count;
    int outstanding;

    // stimulus knobs
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_off_reqs  = 0;
    int hold_off_done  = 0;
    int items_sent     = 0;
    int quiet_cycles;

    // current register settings as written
    logic [u8tr_pkg::BIT_TICKS_W-1:0] cur_bit_ticks = u8tr_pkg::BIT_TICKS_RESET;
    logic [u8tr_pkg::OFFSET_W-1:0]    cur_offset    = u8tr_pkg::OFFSET_RESET;

    logic rx_levels[$];

    uart_8n1_tx_rx_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    uart_8n1_tx_rx_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    // clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // status receiver: random stalls, or a long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off_reqs != hold_off_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
                hold_off_done++;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // one line tick, with random gaps ahead of it
    task automatic send_tick(input logic rx_line, input logic tx_start,
                             input logic [u8tr_pkg::BYTE_W-1:0] tx_byte);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, tx_byte, tx_start, rx_line};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // stop sending and wait until every status has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (4) @(negedge aclk);
    endtask

    // write all three registers, and the unmapped index if asked
    task automatic apply_settings(input logic [u8tr_pkg::BIT_TICKS_W-1:0] bt,
                                  input logic [u8tr_pkg::GUARD_W-1:0] guard,
                                  input logic [u8tr_pkg::OFFSET_W-1:0] off,
                                  input bit poke_unmapped);
        logic [u8tr_pkg::CFG_INDEX_W-1:0] idx[4];
        logic [u8tr_pkg::CFG_DATA_W-1:0]  val[4];
        int                               n;
        idx[0] = u8tr_pkg::CFG_BIT_TICKS;
        val[0] = u8tr_pkg::CFG_DATA_W'(bt);
        idx[1] = u8tr_pkg::CFG_TX_GUARD;
        val[1] = u8tr_pkg::CFG_DATA_W'(guard);
        idx[2] = u8tr_pkg::CFG_RX_OFFSET;
        val[2] = u8tr_pkg::CFG_DATA_W'(off);
        idx[3] = CFG_UNMAPPED;
        val[3] = '1;
        n = poke_unmapped ? 4 : 3;
        settle();
        for (int i = 0; i < n; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            @(negedge aclk);
        end
        cfg_valid     <= 1'b0;
        cur_bit_ticks  = bt;
        cur_offset     = off;
    endtask

    // next stretch of rx levels: mostly frames, some idle and noise
    task automatic queue_rx_pattern();
        int                          p;
        int                          choice;
        int                          cut;
        logic [u8tr_pkg::BYTE_W-1:0] data;
        p      = (cur_bit_ticks == '0) ? 1 : int'(cur_bit_ticks);
        choice = $urandom_range(99);
        if (choice < 70) begin
            // start stretch places each sample near the middle of its bit
            data = 8'($urandom);
            repeat (int'(cur_offset) + p - p / 2) rx_levels.push_back(1'b0);
            for (int k = 0; k < u8tr_pkg::BYTE_W; k++)
                repeat (p) rx_levels.push_back(data[k]);
            repeat (p + $urandom_range(0, 3)) rx_levels.push_back(1'b1);
            // broken frame: cut short
            if ($urandom_range(9) == 0) begin
                cut = $urandom_range(1, rx_levels.size() - 1);
                repeat (cut) void'(rx_levels.pop_back());
            end
        end else if (choice < 85) begin
            repeat ($urandom_range(1, 20)) rx_levels.push_back(1'b1);
        end else begin
            repeat ($urandom_range(1, 10)) rx_levels.push_back(1'($urandom_range(1)));
        end
    endtask

    // stimulus and verdict
    initial begin
        logic [DIRECTED_TICKS-1:0]        rx_pat;
        logic [u8tr_pkg::BIT_TICKS_W-1:0] bt;
        logic [u8tr_pkg::GUARD_W-1:0]     guard;
        logic [u8tr_pkg::OFFSET_W-1:0]    off;
        logic [u8tr_pkg::BYTE_W-1:0]      dir_byte;
        int                               ep;
        int                               n;
        int                               tx_pct;
        int                               p;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // idle line at reset values
        repeat (4) send_tick(1'b1, 1'b0, 8'($urandom));

        // top of every register range, line kept idle
        apply_settings('1, '1, '1, 1'b0);
        repeat (6) send_tick(1'b1, 1'b0, 8'($urandom));

        // directed: zero bit period, no guard, no offset; unmapped write
        apply_settings('0, '0, '0, 1'b1);
        // idle, edge, 0xC3, stop, edge, 0x00, stop, edge, 0xFF
        rx_pat = {8'hFF, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 8'hC3, 1'b0, 1'b1};
        for (int t = 0; t < DIRECTED_TICKS; t++) begin
            // register change while both engines are mid-frame
            if (t == 15)
                apply_settings(u8tr_pkg::BIT_TICKS_W'(3), '0, u8tr_pkg::OFFSET_W'(1), 1'b0);
            if (t == 0)
                dir_byte = 8'hFF;
            else if (t == 11)
                dir_byte = 8'h00;
            else
                dir_byte = 8'h5A;
            // request held high: ignored while busy, then back-to-back
            send_tick(rx_pat[t], t <= 11, dir_byte);
        end

        // bit period of one
        apply_settings(u8tr_pkg::BIT_TICKS_W'(1), u8tr_pkg::GUARD_W'(2), '0, 1'b0);
        repeat (40) begin
            if (rx_levels.size() == 0)
                queue_rx_pattern();
            send_tick(rx_levels.pop_front(), 1'($urandom_range(1)), 8'($urandom));
        end

        // random episodes
        ep = 0;
        while (items_sent < RANDOM_ITEMS) begin
            bt = ($urandom_range(3) == 0) ? u8tr_pkg::BIT_TICKS_W'($urandom_range(7, 20))
                                          : u8tr_pkg::BIT_TICKS_W'($urandom_range(0, 6));
            guard = ($urandom_range(3) == 0) ? u8tr_pkg::GUARD_W'($urandom_range(9, 60))
                                             : u8tr_pkg::GUARD_W'($urandom_range(0, 8));
            p = (bt == '0) ? 1 : int'(bt);
            off = ($urandom_range(3) == 0)
                ? u8tr_pkg::OFFSET_W'($urandom_range(0, 30))
                : u8tr_pkg::OFFSET_W'(p / 2 + $urandom_range(0, 1));
            apply_settings(bt, guard, off, 1'b0);

            case (ep % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 82;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 82;
                end
                default: begin
                    src_idle_pct   = 10;
                    sink_stall_pct = 10;
                end
            endcase
            // long receiver hold-off while ticks keep coming
            if (ep % 8 == 0)
                hold_off_reqs++;

            n      = $urandom_range(80, 200);
            tx_pct = ($urandom_range(4) == 0) ? 100 : $urandom_range(2, 30);
            repeat (n) begin
                if (rx_levels.size() == 0)
                    queue_rx_pattern();
                send_tick(rx_levels.pop_front(), $urandom_range(99) < tx_pct,
                          8'($urandom));
                items_sent++;
            end
            ep++;
        end

        // drain
        s_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
